FILE: src/present128_block_cipher_assert.svh
// assertion macros for the present128 block cipher
// used by the top level only, no other dependencies
`ifndef PRESENT128_BLOCK_CIPHER_ASSERT_SVH
`define PRESENT128_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define P128_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define P128_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/present128_pkg.sv
// shared types, s-box tables and layer functions for the present128 cipher
// no dependencies; used by every other file of the block but the assertion macros
package present128_pkg;

  localparam int BLOCK_W    = 64;
  localparam int KEY_HALF_W = 64;

  // round counter width of the 128-bit key schedule
  typedef logic [4:0] rctr_t;

  typedef logic [BLOCK_W-1:0]    block_t;
  typedef logic [KEY_HALF_W-1:0] khalf_t;

  // one item travelling along the row of round cells
  typedef struct packed {
    logic   valid;
    logic   kind;
    block_t state;
  } stage_t;

  // direction codes
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam logic [3:0] SBOX_REV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  // s-box on all sixteen nibbles
  function automatic block_t sub_fwd(block_t x);
    block_t y;
    for (int n = 0; n < 16; n++) begin
      y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
    end
    return y;
  endfunction

  function automatic block_t sub_rev(block_t x);
    block_t y;
    for (int n = 0; n < 16; n++) begin
      y[4*n +: 4] = SBOX_REV[x[4*n +: 4]];
    end
    return y;
  endfunction

  // bit b moves to 16*(b mod 4) + b/4
  function automatic block_t perm_fwd(block_t x);
    block_t y;
    for (int b = 0; b < 64; b++) begin
      y[(b % 4) * 16 + b / 4] = x[b];
    end
    return y;
  endfunction

  // bit b moves to 4*(b mod 16) + b/16
  function automatic block_t perm_rev(block_t x);
    block_t y;
    for (int b = 0; b < 64; b++) begin
      y[(b % 16) * 4 + b / 16] = x[b];
    end
    return y;
  endfunction

  // one step of the 128-bit key schedule, returns {hi, lo}
  function automatic logic [2*KEY_HALF_W-1:0] key_step(khalf_t hi, khalf_t lo, rctr_t r);
    khalf_t nh;
    khalf_t nl;
    nh = {hi[2:0], lo[63:3]};
    nl = {lo[2:0], hi[63:3]};
    nh[63:60] = SBOX_FWD[nh[63:60]];
    nh[59:56] = SBOX_FWD[nh[59:56]];
    nl[63:62] = nl[63:62] ^ r[1:0];
    nh[2:0]   = nh[2:0] ^ r[4:2];
    return {nh, nl};
  endfunction

endpackage

FILE: src/present128_in_if.sv
// input channel of the present128 cipher: valid/ready with direction and block
// depends on present128_pkg
interface present128_in_if;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  present128_pkg::block_t block_in;

  modport source (output valid, output kind, output block_in, input ready);
  modport sink   (input valid, input kind, input block_in, output ready);
endinterface

FILE: src/present128_out_if.sv
// result channel of the present128 cipher: valid/ready with the output block
// depends on present128_pkg
interface present128_out_if;
  logic                   valid;
  logic                   ready;
  present128_pkg::block_t block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

FILE: src/present128_round_cell.sv
// one round cell: key xor, substitution and permutation in either direction
// depends on present128_pkg
module present128_round_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  present128_pkg::stage_t stage_i,
  input  present128_pkg::khalf_t rk_enc,
  input  present128_pkg::khalf_t rk_dec,
  output present128_pkg::stage_t stage_o
);

  logic                   valid_r;
  logic                   kind_r;
  present128_pkg::block_t state_r;

  present128_pkg::block_t mixed;
  present128_pkg::block_t state_nxt;

  // round function, encrypt or decrypt order of layers
  always_comb begin
    mixed = stage_i.state ^ ((stage_i.kind == present128_pkg::KIND_DEC) ? rk_dec : rk_enc);
    if (stage_i.kind == present128_pkg::KIND_DEC) begin
      state_nxt = present128_pkg::sub_rev(present128_pkg::perm_rev(mixed));
    end else begin
      state_nxt = present128_pkg::perm_fwd(present128_pkg::sub_fwd(mixed));
    end
  end

  // valid flag of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_i.valid;
    end
  end

  // payload of the cell
  always_ff @(posedge clk) begin
    if (en) begin
      kind_r  <= stage_i.kind;
      state_r <= state_nxt;
    end
  end

  assign stage_o = '{valid: valid_r, kind: kind_r, state: state_r};

endmodule

FILE: src/present128_key_sched.sv
// round-key generator: sweeps the 128-bit schedule once per key change
// depends on present128_pkg; holds the round keys in a register file
module present128_key_sched #(
  parameter int ROUND_COUNT = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   restart,
  input  present128_pkg::khalf_t key_high,
  input  present128_pkg::khalf_t key_low,
  output logic                   keys_ready,
  output present128_pkg::khalf_t rk_o [ROUND_COUNT+1]
);

  localparam int NKEY  = ROUND_COUNT + 1;
  localparam int CNT_W = (NKEY > 1) ? $clog2(NKEY) : 1;

  logic                   start_r;
  logic                   busy_r;
  logic [CNT_W-1:0]       cnt_r;
  present128_pkg::khalf_t hi_r;
  present128_pkg::khalf_t lo_r;
  present128_pkg::khalf_t rk_r [NKEY];

  logic                   last_key;
  present128_pkg::rctr_t  rctr;
  logic [127:0]           step_nxt;

  assign last_key = (cnt_r == CNT_W'(ROUND_COUNT));
  assign rctr     = present128_pkg::rctr_t'(cnt_r) + present128_pkg::rctr_t'(1);
  assign step_nxt = present128_pkg::key_step(hi_r, lo_r, rctr);

  // sweep control: a start cycle, then one round key per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (restart) begin
      start_r <= 1'b1;
      busy_r  <= 1'b0;
    end else if (start_r) begin
      start_r <= 1'b0;
      busy_r  <= 1'b1;
      cnt_r   <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last_key) begin
        busy_r <= 1'b0;
      end
    end
  end

  // schedule state and round-key file
  always_ff @(posedge clk) begin
    if (start_r) begin
      hi_r <= key_high;
      lo_r <= key_low;
    end else if (busy_r) begin
      hi_r          <= step_nxt[127:64];
      lo_r          <= step_nxt[63:0];
      rk_r[cnt_r]   <= hi_r;
    end
  end

  assign keys_ready = !start_r && !busy_r;
  assign rk_o       = rk_r;

endmodule

FILE: src/present128_block_cipher.sv
// PRESENT block cipher with a 128-bit key, one 64-bit block per cycle in
// either direction. Each of ROUND_COUNT round cells does one round and hands
// the block on each cycle the row advances; a final whitening stage drives the
// result register, and a new block is taken every cycle while the result side
// keeps taking. The round keys live in a register file filled by a schedule
// sweep after reset and after every key write; while a sweep runs, input ready
// stays low.
// Depends on present128_pkg, the channel interfaces, the round cell, the key
// schedule and the assertion macros.
`include "present128_block_cipher_assert.svh"

module present128_block_cipher #(
  parameter int ROUND_COUNT = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  present128_in_if.sink          in_ch,
  present128_out_if.source       out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  present128_pkg::khalf_t key_high_r;
  present128_pkg::khalf_t key_low_r;
  logic                   cfg_wr;
  logic                   keys_ready;
  present128_pkg::khalf_t rk [ROUND_COUNT+1];

  logic                   adv;
  present128_pkg::stage_t stg_in;
  present128_pkg::stage_t stg [ROUND_COUNT];
  present128_pkg::khalf_t wkey;

  logic                   out_valid_r;
  present128_pkg::block_t block_out_r;

  // key registers on the apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? key_low_r : key_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        key_low_r <= pwdata;
      end else begin
        key_high_r <= pwdata;
      end
    end
  end

  present128_key_sched #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_key_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .key_high   (key_high_r),
    .key_low    (key_low_r),
    .keys_ready (keys_ready),
    .rk_o       (rk)
  );

  // whole row moves unless a result waits to be taken
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = keys_ready && adv;
  assign stg_in.valid = in_ch.valid && keys_ready;
  assign stg_in.kind  = in_ch.kind;
  assign stg_in.state = in_ch.block_in;

  // row of round cells
  for (genvar gi = 0; gi < ROUND_COUNT; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      present128_round_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .stage_i (stg_in),
        .rk_enc  (rk[gi]),
        .rk_dec  (rk[ROUND_COUNT-gi]),
        .stage_o (stg[gi])
      );
    end else begin : g_next
      present128_round_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .stage_i (stg[gi-1]),
        .rk_enc  (rk[gi]),
        .rk_dec  (rk[ROUND_COUNT-gi]),
        .stage_o (stg[gi])
      );
    end
  end

  // final whitening into the result register
  assign wkey = (stg[ROUND_COUNT-1].kind == present128_pkg::KIND_DEC) ? rk[0] : rk[ROUND_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg[ROUND_COUNT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      block_out_r <= stg[ROUND_COUNT-1].state ^ wkey;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.block_out = block_out_r;

  // checks
  `P128_ASSERT_SAME(a_no_take_in_sweep, clk, rst_n, !keys_ready, !(in_ch.valid && in_ch.ready), "input transfer during round-key sweep")
  `P128_ASSERT_NEXT(a_wr_stalls_input, clk, rst_n, cfg_wr, !in_ch.ready, "input ready high just after a key write")
  `P128_ASSERT_NEXT(a_take_enters_row, clk, rst_n, in_ch.valid && in_ch.ready, stg[0].valid, "accepted block missing in first cell")
  `P128_ASSERT_NEXT(a_last_cell_to_out, clk, rst_n, adv && stg[ROUND_COUNT-1].valid, out_valid_r, "block lost between last cell and result register")

endmodule
